// File: sv/chained_hash_find_or_insert_top_defines.svh
`ifndef CHAINED_HASH_FIND_OR_INSERT_TOP_DEFINES_SVH
`define CHAINED_HASH_FIND_OR_INSERT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, quiet during reset.
`define CHFI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, quiet during reset.
`define CHFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/chfi_pkg.sv
`timescale 1ns / 1ps

package chfi_pkg;

  localparam int BUCKETS      = 256;
  localparam int POOL_ENTRIES = 1024;

  localparam int KEY_W      = 31;
  localparam int HANDLE_W   = 11;
  localparam int STATUS_W   = 2;
  localparam int BUCKET_W   = $clog2(BUCKETS);
  localparam int POOL_IDX_W = $clog2(POOL_ENTRIES);
  localparam int FILL_W     = $clog2(POOL_ENTRIES + 1);

  localparam logic OP_FIND  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_FOUND    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 2'd3;

  localparam logic [HANDLE_W-1:0] LINK_NULL = '0;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HEAD = 4'b0010,
    S_POOL = 4'b0100,
    S_LINK = 4'b1000
  } state_e;

  function automatic logic link_ok(input logic [HANDLE_W-1:0] link);
    return (link >= HANDLE_W'(BUCKETS)) && (link < HANDLE_W'(BUCKETS + POOL_ENTRIES));
  endfunction

  function automatic logic [POOL_IDX_W-1:0] link_idx(input logic [HANDLE_W-1:0] link);
    logic [HANDLE_W-1:0] diff;
    diff = link - HANDLE_W'(BUCKETS);
    return diff[POOL_IDX_W-1:0];
  endfunction

  function automatic logic [HANDLE_W-1:0] idx_link(input logic [POOL_IDX_W-1:0] idx);
    return HANDLE_W'(BUCKETS) + HANDLE_W'(idx);
  endfunction

endpackage

// File: sv/chfi_if.sv
`timescale 1ns / 1ps

interface chfi_req_if;
  logic                       valid;
  logic                       ready;
  logic                       operation;
  logic [chfi_pkg::KEY_W-1:0] label_key;

  modport source (output valid, output operation, output label_key, input ready);
  modport sink   (input valid, input operation, input label_key, output ready);
endinterface

interface chfi_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [chfi_pkg::HANDLE_W-1:0] entry_handle;
  logic [chfi_pkg::STATUS_W-1:0] status;

  modport source (output valid, output entry_handle, output status, input ready);
  modport sink   (input valid, input entry_handle, input status, output ready);
endinterface

// File: sv/chained_hash_find_or_insert_top.sv
// Separate-chaining symbol table. Each request either clears the whole table or looks up a
// label key in bucket key mod 256, returning the entry handle (0..255 head slot, 256..1279
// overflow entry) and a status (found, inserted, pool full, cleared). One request is handled at
// a time through a small sequencer around single-port key and link memories: a clear or an
// insert into an empty bucket completes on acceptance, a hit in the head slot needs the head
// memory read (S_HEAD), each overflow entry walked adds a pool memory read (S_POOL), and
// appending a new entry to a chain adds a step to write the tail link (S_LINK). A pending
// result does not block the next request as long as it is taken in the same cycle. Bucket
// occupancy lives in flip-flops, so reset and clear take effect at once with no memory sweep.
`timescale 1ns / 1ps

`include "chained_hash_find_or_insert_top_defines.svh"

module chained_hash_find_or_insert_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  chfi_req_if.sink   req_i,
  chfi_rsp_if.source rsp_o
);
  import chfi_pkg::*;

  state_e                state_q, state_d;
  logic [KEY_W-1:0]      key_q, key_d;
  logic [HANDLE_W-1:0]   link_q, link_d;
  logic                  tail_is_head_q, tail_is_head_d;
  logic [POOL_IDX_W-1:0] tail_idx_q, tail_idx_d;
  logic [POOL_IDX_W-1:0] new_idx_q, new_idx_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic [BUCKETS-1:0]    head_used_q, head_used_d;
  logic                  out_valid_q, out_valid_d;
  logic [HANDLE_W-1:0]   out_handle_q, out_handle_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;

  logic [KEY_W-1:0]      head_key_mem [BUCKETS];
  logic [HANDLE_W-1:0]   head_link_mem [BUCKETS];
  logic [KEY_W-1:0]      pool_key_mem [POOL_ENTRIES];
  logic [HANDLE_W-1:0]   pool_link_mem [POOL_ENTRIES];

  logic                  head_re;
  logic [BUCKET_W-1:0]   head_raddr;
  logic [KEY_W-1:0]      head_key_rd_q;
  logic [HANDLE_W-1:0]   head_link_rd_q;
  logic                  head_key_we;
  logic                  head_link_we;
  logic [BUCKET_W-1:0]   head_waddr;
  logic [HANDLE_W-1:0]   head_link_wdata;

  logic                  pool_re;
  logic [POOL_IDX_W-1:0] pool_raddr;
  logic [KEY_W-1:0]      pool_key_rd_q;
  logic [HANDLE_W-1:0]   pool_link_rd_q;
  logic                  pool_key_we;
  logic                  pool_link_we;
  logic [POOL_IDX_W-1:0] pool_key_waddr;
  logic [POOL_IDX_W-1:0] pool_link_waddr;
  logic [HANDLE_W-1:0]   pool_link_wdata;

  logic                  req_fire;
  logic [BUCKET_W-1:0]   req_bucket;
  logic [BUCKET_W-1:0]   cur_bucket;
  logic                  walk;
  logic [HANDLE_W-1:0]   walk_link;
  logic                  res_valid;
  logic [HANDLE_W-1:0]   res_handle;
  logic [STATUS_W-1:0]   res_status;

  assign req_i.ready  = (state_q == S_IDLE) && (!out_valid_q || rsp_o.ready);
  assign req_fire     = req_i.valid && req_i.ready;
  assign req_bucket   = req_i.label_key[BUCKET_W-1:0];
  assign cur_bucket   = key_q[BUCKET_W-1:0];

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.entry_handle = out_handle_q;
  assign rsp_o.status       = out_status_q;

  always_comb begin
    state_d         = state_q;
    key_d           = key_q;
    link_d          = link_q;
    tail_is_head_d  = tail_is_head_q;
    tail_idx_d      = tail_idx_q;
    new_idx_d       = new_idx_q;
    fill_d          = fill_q;
    head_used_d     = head_used_q;

    head_re         = 1'b0;
    head_raddr      = req_bucket;
    head_key_we     = 1'b0;
    head_link_we    = 1'b0;
    head_waddr      = cur_bucket;
    head_link_wdata = LINK_NULL;

    pool_re         = 1'b0;
    pool_raddr      = '0;
    pool_key_we     = 1'b0;
    pool_link_we    = 1'b0;
    pool_key_waddr  = fill_q[POOL_IDX_W-1:0];
    pool_link_waddr = fill_q[POOL_IDX_W-1:0];
    pool_link_wdata = LINK_NULL;

    walk            = 1'b0;
    walk_link       = head_link_rd_q;
    res_valid       = 1'b0;
    res_handle      = '0;
    res_status      = STATUS_FOUND;

    case (state_q)
      S_IDLE: begin
        if (req_fire) begin
          if (req_i.operation == OP_CLEAR) begin
            head_used_d = '0;
            fill_d      = '0;
            res_valid   = 1'b1;
            res_status  = STATUS_CLEARED;
          end else begin
            key_d = req_i.label_key;
            if (!head_used_q[req_bucket]) begin
              head_used_d[req_bucket] = 1'b1;
              head_key_we  = 1'b1;
              head_link_we = 1'b1;
              head_waddr   = req_bucket;
              res_valid    = 1'b1;
              res_handle   = HANDLE_W'(req_bucket);
              res_status   = STATUS_INSERTED;
            end else begin
              head_re = 1'b1;
              state_d = S_HEAD;
            end
          end
        end
      end
      S_HEAD: begin
        if (head_key_rd_q == key_q) begin
          res_valid  = 1'b1;
          res_handle = HANDLE_W'(cur_bucket);
          res_status = STATUS_FOUND;
          state_d    = S_IDLE;
        end else begin
          tail_is_head_d = 1'b1;
          walk           = 1'b1;
          walk_link      = head_link_rd_q;
        end
      end
      S_POOL: begin
        if (pool_key_rd_q == key_q) begin
          res_valid  = 1'b1;
          res_handle = link_q;
          res_status = STATUS_FOUND;
          state_d    = S_IDLE;
        end else begin
          tail_is_head_d = 1'b0;
          tail_idx_d     = link_idx(link_q);
          walk           = 1'b1;
          walk_link      = pool_link_rd_q;
        end
      end
      S_LINK: begin
        if (tail_is_head_q) begin
          head_link_we    = 1'b1;
          head_link_wdata = idx_link(new_idx_q);
        end else begin
          pool_link_we    = 1'b1;
          pool_link_waddr = tail_idx_q;
          pool_link_wdata = idx_link(new_idx_q);
        end
        res_valid  = 1'b1;
        res_handle = idx_link(new_idx_q);
        res_status = STATUS_INSERTED;
        state_d    = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (walk) begin
      if (link_ok(walk_link)) begin
        pool_re    = 1'b1;
        pool_raddr = link_idx(walk_link);
        link_d     = walk_link;
        state_d    = S_POOL;
      end else if (fill_q == FILL_W'(POOL_ENTRIES)) begin
        res_valid  = 1'b1;
        res_status = STATUS_FULL;
        state_d    = S_IDLE;
      end else begin
        pool_key_we  = 1'b1;
        pool_link_we = 1'b1;
        new_idx_d    = fill_q[POOL_IDX_W-1:0];
        fill_d       = fill_q + FILL_W'(1);
        state_d      = S_LINK;
      end
    end

    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_handle_d = out_handle_q;
    out_status_d = out_status_q;
    if (res_valid) begin
      out_valid_d  = 1'b1;
      out_handle_d = res_handle;
      out_status_d = res_status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      head_used_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      head_used_q <= head_used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q          <= key_d;
    link_q         <= link_d;
    tail_is_head_q <= tail_is_head_d;
    tail_idx_q     <= tail_idx_d;
    new_idx_q      <= new_idx_d;
    out_handle_q   <= out_handle_d;
    out_status_q   <= out_status_d;
  end

  always_ff @(posedge clk_i) begin
    if (head_key_we) begin
      head_key_mem[head_waddr] <= key_d;
    end
    if (head_link_we) begin
      head_link_mem[head_waddr] <= head_link_wdata;
    end
    if (head_re) begin
      head_key_rd_q  <= head_key_mem[head_raddr];
      head_link_rd_q <= head_link_mem[head_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pool_key_we) begin
      pool_key_mem[pool_key_waddr] <= key_q;
    end
    if (pool_link_we) begin
      pool_link_mem[pool_link_waddr] <= pool_link_wdata;
    end
    if (pool_re) begin
      pool_key_rd_q  <= pool_key_mem[pool_raddr];
      pool_link_rd_q <= pool_link_mem[pool_raddr];
    end
  end

  `CHFI_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= FILL_W'(POOL_ENTRIES), "pool fill overrun")
  `CHFI_ASSERT_NEXT(a_clear_result, req_fire && (req_i.operation == OP_CLEAR), rsp_o.valid && (rsp_o.status == STATUS_CLEARED) && (fill_q == '0), "clear not reported")
  `CHFI_ASSERT_NOW(a_busy_no_result, state_q != S_IDLE, !out_valid_q, "result pending while busy")
  `CHFI_ASSERT_NOW(a_pool_handle_live, rsp_o.valid && (rsp_o.entry_handle >= HANDLE_W'(BUCKETS)), (rsp_o.entry_handle - HANDLE_W'(BUCKETS)) < HANDLE_W'(fill_q), "handle beyond pool fill")

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import chfi_pkg::*;

  localparam int HOLD_CYCLES      = 300;
  localparam int IDLE_LIMIT       = 5000;
  localparam int SETTLE_CYCLES    = 20;
  localparam int RANDOM_PER_PHASE = 143;
  localparam int FILL_ROUNDS      = 1;
  localparam int UPPER_W          = KEY_W - BUCKET_W;

  typedef struct packed {
    logic             operation;
    logic [KEY_W-1:0] label_key;
  } request_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] entry_handle;
    logic [STATUS_W-1:0] status;
  } answer_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  chfi_req_if req_if ();
  chfi_rsp_if rsp_if ();

  chained_hash_find_or_insert_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #10 clk_i = ~clk_i;

  request_t pending_requests[$];
  answer_t  expected_answers[$];

  bit               head_used[BUCKETS];
  logic [KEY_W-1:0] head_key[BUCKETS];
  int               head_link[BUCKETS];
  logic [KEY_W-1:0] pool_key[POOL_ENTRIES];
  int               pool_link[POOL_ENTRIES];
  int               pool_fill;

  int       src_idle_pct;
  int       snk_idle_pct;
  bit       hold_request;
  bit       hold_started;
  int       hold_left;
  int       idle_cycles;
  int       mismatches;
  int       requests_accepted;
  int       status_seen[4];
  request_t next_request;

  function automatic void empty_table();
    foreach (head_used[i]) begin
      head_used[i] = 1'b0;
      head_link[i] = 0;
    end
    pool_fill = 0;
  endfunction

  function automatic answer_t lookup_or_insert(logic [KEY_W-1:0] key);
    answer_t a;
    int      b;
    int      link;
    int      idx;
    int      tail;
    bit      tail_is_head;
    b            = int'(key[BUCKET_W-1:0]);
    tail         = 0;
    tail_is_head = 1'b1;
    a.entry_handle = '0;
    a.status       = STATUS_FOUND;
    if (!head_used[b]) begin
      head_used[b]   = 1'b1;
      head_key[b]    = key;
      head_link[b]   = 0;
      a.entry_handle = HANDLE_W'(b);
      a.status       = STATUS_INSERTED;
      return a;
    end
    if (head_key[b] == key) begin
      a.entry_handle = HANDLE_W'(b);
      return a;
    end
    link = head_link[b];
    for (int steps = 0; steps < POOL_ENTRIES; steps++) begin
      if (link < BUCKETS || link - BUCKETS >= POOL_ENTRIES) break;
      idx = link - BUCKETS;
      if (pool_key[idx] == key) begin
        a.entry_handle = HANDLE_W'(link);
        return a;
      end
      tail_is_head = 1'b0;
      tail         = idx;
      link         = pool_link[idx];
    end
    if (pool_fill >= POOL_ENTRIES) begin
      a.status = STATUS_FULL;
      return a;
    end
    idx            = pool_fill;
    pool_fill      = pool_fill + 1;
    pool_key[idx]  = key;
    pool_link[idx] = 0;
    link           = BUCKETS + idx;
    if (tail_is_head) head_link[b] = link;
    else pool_link[tail] = link;
    a.entry_handle = HANDLE_W'(link);
    a.status       = STATUS_INSERTED;
    return a;
  endfunction

  function automatic answer_t predict_answer(request_t r);
    answer_t a;
    if (r.operation == OP_CLEAR) begin
      empty_table();
      a.entry_handle = '0;
      a.status       = STATUS_CLEARED;
      return a;
    end
    return lookup_or_insert(r.label_key);
  endfunction

  function automatic void check_answer(answer_t got);
    answer_t want;
    status_seen[got.status]++;
    if (expected_answers.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected response handle=%0d status=%0d",
                 $time, got.entry_handle, got.status);
      return;
    end
    want = expected_answers.pop_front();
    if (got.entry_handle !== want.entry_handle || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: expected handle=%0d status=%0d, got handle=%0d status=%0d",
                 $time, want.entry_handle, want.status, got.entry_handle, got.status);
    end
  endfunction

  function automatic request_t random_request();
    request_t  r;
    int        pick;
    bit [31:0] upper;
    bit [31:0] bucket;
    pick        = $urandom_range(99);
    r.operation = OP_FIND;
    r.label_key = KEY_W'($urandom);
    if (pick < 3) begin
      r.operation = OP_CLEAR;
    end else if (pick >= 18) begin
      upper  = (pick < 25) ? $urandom_range((1 << UPPER_W) - 1, 0) : $urandom_range(11, 0);
      bucket = (pick < 70) ? $urandom_range(15, 0) : $urandom_range(BUCKETS - 1, 0);
      r.label_key = {upper[UPPER_W-1:0], bucket[BUCKET_W-1:0]};
    end
    return r;
  endfunction

  task automatic push_request(logic op, logic [KEY_W-1:0] key);
    request_t r;
    r.operation = op;
    r.label_key = key;
    pending_requests.push_back(r);
  endtask

  task automatic queue_random(int count);
    repeat (count) pending_requests.push_back(random_request());
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (pending_requests.size() > 0 || req_if.valid || expected_answers.size() > 0)
      @(negedge clk_i);
  endtask

  function automatic logic [KEY_W-1:0] fill_key(int round, int b);
    bit [31:0] upper;
    bit [31:0] bucket;
    upper  = round * 1000 + 7;
    bucket = b;
    return {upper[UPPER_W-1:0], bucket[BUCKET_W-1:0]};
  endfunction

  // driver: predict at acceptance, offer next request when the slot is free
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_FIND;
      req_if.label_key <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        expected_answers.push_back(predict_answer({req_if.operation, req_if.label_key}));
        requests_accepted++;
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          next_request      = pending_requests.pop_front();
          req_if.valid     <= 1'b1;
          req_if.operation <= next_request.operation;
          req_if.label_key <= next_request.label_key;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each response, hold off once for a long stretch
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      hold_started <= 1'b0;
      hold_left    <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) check_answer({rsp_if.entry_handle, rsp_if.status});
      if (hold_request && !hold_started) begin
        hold_started <= 1'b1;
        hold_left    <= HOLD_CYCLES;
        rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left    <= hold_left - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                 $time, IDLE_LIMIT, expected_answers.size());
        $display("Simulation FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    src_idle_pct     = 34;
    snk_idle_pct     = 65;
    empty_table();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_request(OP_CLEAR, '0);
    push_request(OP_FIND, 31'd0);
    push_request(OP_FIND, 31'd0);
    push_request(OP_FIND, 31'd256);
    push_request(OP_FIND, 31'd512);
    push_request(OP_FIND, 31'd512);
    push_request(OP_FIND, 31'd256);
    push_request(OP_FIND, 31'h7FFF_FFFF);
    push_request(OP_FIND, 31'h7FFF_FEFF);
    push_request(OP_FIND, 31'h0000_00FF);
    push_request(OP_FIND, 31'h7FFF_FFFF);
    push_request(OP_FIND, 31'h0000_00FF);
    push_request(OP_FIND, 31'h5555_5555);
    push_request(OP_FIND, 31'h2AAA_AAAA);
    push_request(OP_FIND, 31'h2AAA_AB55);
    push_request(OP_FIND, 31'h5555_5555);
    push_request(OP_CLEAR, 31'h7FFF_FFFF);
    push_request(OP_FIND, 31'd0);
    push_request(OP_FIND, 31'd256);
    push_request(OP_FIND, 31'h7FFF_FEFF);
    push_request(OP_CLEAR, '0);
    queue_random(RANDOM_PER_PHASE);
    drain();

    src_idle_pct = 65;
    snk_idle_pct = 34;
    queue_random(RANDOM_PER_PHASE);
    drain();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_request = 1'b1;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // occupy every head slot, revisit some keys, then chain random keys behind them
    push_request(OP_CLEAR, '0);
    for (int round = 0; round < FILL_ROUNDS; round++)
      for (int b = 0; b < BUCKETS; b++) push_request(OP_FIND, fill_key(round, b));
    repeat (30)
      push_request(OP_FIND, fill_key($urandom_range(FILL_ROUNDS - 1, 0),
                                     $urandom_range(BUCKETS - 1, 0)));
    repeat (10) push_request(OP_FIND, KEY_W'($urandom));
    push_request(OP_CLEAR, '0);
    push_request(OP_FIND, fill_key(FILL_ROUNDS - 1, 3));
    push_request(OP_FIND, fill_key(0, 3));
    drain();

    repeat (SETTLE_CYCLES) @(negedge clk_i);
    $display("Run covered %0d requests over three idling mixes, a long receiver stall",
             requests_accepted);
    $display("and every head slot in use: %0d found, %0d inserted, %0d pool full, %0d cleared",
             status_seen[STATUS_FOUND], status_seen[STATUS_INSERTED],
             status_seen[STATUS_FULL], status_seen[STATUS_CLEARED]);
    if (expected_answers.size() > 0)
      $display("%0d responses never arrived", expected_answers.size());
    if (mismatches > 0) $display("%0d mismatches", mismatches);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
